@@ rtl/bfis_pkg.sv @@
// shared types and constants of the bloom filter core
package bfis_pkg;

    localparam int MAX_BYTES  = 4096;
    localparam int NUM_HASHES = 16;

    localparam int HASH_W     = 64;
    localparam int SIZE_W     = 13;
    localparam int ADDR_W     = $clog2(MAX_BYTES);
    localparam int NBITS_W    = $clog2(MAX_BYTES * 8) + 1;
    localparam int IDX_W      = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYC    = HASH_W / DIV_STEP;
    localparam int DCNT_W     = $clog2(DIV_CYC);

    localparam logic [HASH_W-1:0] DJB_START = HASH_W'(5381);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic               op;
        logic [HASH_W-1:0]  djb;
        logic [HASH_W-1:0]  sdbm;
        logic [NBITS_W-1:0] nbits;
    } t_job;

endpackage

@@ rtl/bfis_ram.sv @@
// generic single write, single registered read ram
module bfis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bfis_front.sv @@
// front end: byte hashing and job build on the last byte
module bfis_front import bfis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_operation,
    input  logic [7:0]        i_key_byte,
    input  logic              i_last_byte,
    input  logic [SIZE_W-1:0] i_filter_bytes,
    output logic              o_push,
    output t_job              o_job
);

    logic [HASH_W-1:0]  r_djb, r_sdbm, n_djb, n_sdbm;
    logic               r_ended;
    logic [HASH_W-1:0]  upd_djb, upd_sdbm;
    logic [SIZE_W-1:0]  used;
    logic [NBITS_W-1:0] nbits;

    always_comb begin
        upd_djb  = r_djb;
        upd_sdbm = r_sdbm;
        if (!r_ended && i_key_byte != 8'd0) begin
            upd_djb  = (r_djb << 5) + r_djb + HASH_W'(i_key_byte);
            upd_sdbm = (r_sdbm << 16) + (r_sdbm << 6) - r_sdbm + HASH_W'(i_key_byte);
        end
        n_djb  = upd_djb;
        n_sdbm = upd_sdbm;
    end

    // clamp the size to 1 .. max
    always_comb begin
        priority if (i_filter_bytes == '0) begin
            used = SIZE_W'(1);
        end else if (i_filter_bytes > SIZE_W'(MAX_BYTES)) begin
            used = SIZE_W'(MAX_BYTES);
        end else begin
            used = i_filter_bytes;
        end
        nbits = NBITS_W'({used, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_djb   <= DJB_START;
            r_sdbm  <= '0;
            r_ended <= 1'b0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_djb   <= DJB_START;
                r_sdbm  <= '0;
                r_ended <= 1'b0;
            end else begin
                r_djb   <= n_djb;
                r_sdbm  <= n_sdbm;
                r_ended <= r_ended | (i_key_byte == 8'd0);
            end
        end
    end

    assign o_push      = i_accept & i_last_byte;
    assign o_job.op    = i_operation;
    assign o_job.djb   = upd_djb;
    assign o_job.sdbm  = upd_sdbm;
    assign o_job.nbits = nbits;

endmodule

@@ rtl/bfis_queue.sv @@
// two entry job queue between front and back
module bfis_queue import bfis_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

@@ rtl/bfis_back.sv @@
// back end: clear pass, probe generation, modulo and bit store access
module bfis_back import bfis_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_clearing,
    output logic o_valid,
    output logic o_found,
    output logic o_was_search
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;

    logic [2:0]         r_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [HASH_W-1:0]  r_acc, r_delta, r_div;
    logic [NBITS_W-1:0] r_nbits, r_rem, n_rem;
    logic [HASH_W-1:0]  n_div;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [IDX_W-1:0]   r_idx;
    logic               r_op, r_all;
    logic               r_valid, r_found, r_was;

    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [7:0]         wdata, rdata;
    logic [7:0]         mask;
    logic [HASH_W-1:0]  nxt_acc;

    // four restoring remainder steps per cycle
    always_comb begin
        logic [NBITS_W-1:0] t;
        t     = r_rem;
        n_div = r_div;
        for (int k = 0; k < DIV_STEP; k++) begin
            t     = {t[NBITS_W-2:0], n_div[HASH_W-1]};
            n_div = n_div << 1;
            if (t >= r_nbits) t = t - r_nbits;
        end
        n_rem = t;
    end

    assign mask    = 8'(1) << r_rem[2:0];
    assign nxt_acc = r_acc + r_delta;
    assign raddr   = r_rem[ADDR_W+2:3];
    assign re      = (r_state == ST_RD);

    always_comb begin
        we    = 1'b0;
        waddr = raddr;
        wdata = rdata | mask;
        if (r_state == ST_CLR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = 8'd0;
        end else if (r_state == ST_CHK && r_op == OP_INSERT) begin
            we = 1'b1;
        end
    end

    bfis_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MAX_BYTES - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (!i_empty) r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_dcnt == DCNT_W'(DIV_CYC - 1)) r_state <= ST_RD;
                end
                ST_RD: begin
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_idx == IDX_W'(NUM_HASHES - 1)) begin
                        r_state <= ST_IDLE;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op    <= i_job.op;
                r_nbits <= i_job.nbits;
                r_acc   <= i_job.djb;
                r_delta <= i_job.sdbm + HASH_W'(1);
                r_div   <= i_job.djb;
                r_rem   <= '0;
                r_dcnt  <= '0;
                r_idx   <= '0;
                r_all   <= 1'b1;
            end
            ST_DIV: begin
                r_div  <= n_div;
                r_rem  <= n_rem;
                r_dcnt <= r_dcnt + 1'b1;
            end
            ST_CHK: begin
                if (r_op == OP_SEARCH && (rdata & mask) == 8'd0) r_all <= 1'b0;
                // next probe: second difference of i*s + i*i is 2
                r_acc   <= nxt_acc;
                r_delta <= r_delta + HASH_W'(2);
                r_div   <= nxt_acc;
                r_rem   <= '0;
                r_dcnt  <= '0;
                r_idx   <= r_idx + 1'b1;
                r_found <= (r_op == OP_SEARCH) && r_all &&
                           ((rdata & mask) != 8'd0);
                r_was   <= r_op;
            end
            default: ;
        endcase
    end

    assign o_pop        = (r_state == ST_IDLE) && !i_empty;
    assign o_clearing   = (r_state == ST_CLR);
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_was_search = r_was;

endmodule

@@ rtl/bloom_filter_insert_search_core.sv @@
// top level of the bloom filter insert and search core
//
// channel   direction  signals                                    handshake
// command   in         i_operation, i_key_byte, i_last_byte       start & !busy
// result    out        o_found, o_was_search                      o_valid strobe
// config    in         i_cfg_wdata (filter_bytes)                 i_cfg_we
//
// each key byte is taken by the front end hashing stage while start is high and busy low
// a key's last byte queues a job; the back end then takes one key at a time and, for
// each of its 16 probes, runs a modulo (4 remainder bits a cycle), one ram read and
// one check or read-modify-write, so the modulo rather than the ram port sets the pace
// busy is high while the 2 entry job queue is full, and during the clearing pass over
// all 4096 bytes of the bit store after reset
// results are strobed for one cycle and cannot be held off
module bloom_filter_insert_search_core import bfis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [7:0]        i_key_byte,
    input  logic              i_last_byte,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              o_valid,
    output logic              o_found,
    output logic              o_was_search
);

    logic [SIZE_W-1:0] r_filter_bytes;
    logic              accept, push, pop, empty, full, clearing;
    t_job              push_job, head_job;

    // size register, reset to the full store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bytes <= SIZE_W'(MAX_BYTES);
        end else if (i_cfg_we) begin
            r_filter_bytes <= i_cfg_wdata;
        end
    end

    assign busy   = full | clearing;
    assign accept = start & ~busy;

    bfis_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_operation    (i_operation),
        .i_key_byte     (i_key_byte),
        .i_last_byte    (i_last_byte),
        .i_filter_bytes (r_filter_bytes),
        .o_push         (push),
        .o_job          (push_job)
    );

    bfis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty),
        .o_full  (full)
    );

    bfis_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_was_search (o_was_search)
    );

`ifndef ASSERT_OFF
    // an insert never reports a hit
    a_insert_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_was_search |-> !o_found)
        else $error("insert reported found");

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("job queue overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> !pop)
        else $error("job queue underflow");

    // results are single cycle strobes
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

@@ tb/bfis_checker.sv @@
// checker of the bloom filter core: predicts every key answer and compares it
`timescale 1ns / 100ps

module bfis_checker import bfis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_operation,
    input  logic [7:0]        i_key_byte,
    input  logic              i_last_byte,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    input  logic              i_found,
    input  logic              i_was_search,
    output int                o_pending,
    output int                o_fail_cnt,
    output int                o_hit_cnt
);

    typedef struct {
        logic found;
        logic was_search;
    } key_answer_t;

    key_answer_t        answers_q[$];
    logic [7:0]         filt_mirror [MAX_BYTES];
    logic [HASH_W-1:0]  djb_acc;
    logic [HASH_W-1:0]  sdbm_acc;
    logic               key_done;
    logic [SIZE_W-1:0]  size_reg;

    assign o_pending = answers_q.size();

    // probe the mirror for the key hashed so far; inserts set bits
    function automatic logic probe_key(input logic op);
        int unsigned       used;
        logic [HASH_W-1:0] nbits;
        logic [HASH_W-1:0] p;
        logic [HASH_W-1:0] bitn;
        logic              all_set;
        used = (size_reg == 0) ? 1 : ((size_reg > MAX_BYTES) ? MAX_BYTES : size_reg);
        nbits = HASH_W'(used) * 8;
        all_set = 1'b1;
        for (int i = 0; i < NUM_HASHES; i++) begin
            p = djb_acc + HASH_W'(i) * sdbm_acc + HASH_W'(i * i);
            bitn = p % nbits;
            if (op == OP_INSERT)
                filt_mirror[bitn >> 3][bitn[2:0]] = 1'b1;
            else if (!filt_mirror[bitn >> 3][bitn[2:0]])
                all_set = 1'b0;
        end
        return (op == OP_SEARCH) && all_set;
    endfunction

    always @(posedge i_clk) begin
        key_answer_t ans;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BYTES; k++) filt_mirror[k] = 8'h00;
            djb_acc = DJB_START;
            sdbm_acc = '0;
            key_done = 1'b0;
            size_reg = SIZE_W'(MAX_BYTES);
            answers_q.delete();
            o_fail_cnt = 0;
            o_hit_cnt = 0;
        end else begin
            // result side: compare with the oldest expectation
            if (i_valid) begin
                if (answers_q.size() == 0) begin
                    $display("%0t: unexpected result word found=%b was_search=%b",
                             $time, i_found, i_was_search);
                    o_fail_cnt++;
                end else begin
                    ans = answers_q.pop_front();
                    if (i_found !== ans.found) begin
                        $display("%0t: found mismatch: expected %b, actual %b",
                                 $time, ans.found, i_found);
                        o_fail_cnt++;
                    end
                    if (i_was_search !== ans.was_search) begin
                        $display("%0t: was_search mismatch: expected %b, actual %b",
                                 $time, ans.was_search, i_was_search);
                        o_fail_cnt++;
                    end
                    if (ans.found) o_hit_cnt++;
                end
            end
            // command side: hash the accepted word, probe on the last byte
            if (i_start && !i_busy) begin
                if (!key_done) begin
                    if (i_key_byte == 8'h00) begin
                        key_done = 1'b1;
                    end else begin
                        djb_acc = djb_acc * 33 + HASH_W'(i_key_byte);
                        sdbm_acc = sdbm_acc * 65599 + HASH_W'(i_key_byte);
                    end
                end
                if (i_last_byte) begin
                    ans.found = probe_key(i_operation);
                    ans.was_search = i_operation;
                    answers_q.push_back(ans);
                    djb_acc = DJB_START;
                    sdbm_acc = '0;
                    key_done = 1'b0;
                end
            end
            if (i_cfg_we) size_reg = i_cfg_wdata;
        end
    end

endmodule

@@ tb/tb_top.sv @@
// top of the bloom filter core testbench: stimulus, size phases and verdict
`timescale 1ns / 100ps

module tb_top;
    import bfis_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_operation;
    logic [7:0]        i_key_byte;
    logic              i_last_byte;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;
    logic              o_valid;
    logic              o_found;
    logic              o_was_search;

    int pending;
    int fail_cnt;
    int hit_cnt;

    // stimulus bookkeeping
    int          words_sent;
    int          keys_sent;
    int          gap_pct;
    logic        idle_off;
    logic [7:0]  cur_key [8];
    int          cur_len;
    // ring of inserted keys so that searches can hit
    logic [7:0]  stored_key [64][8];
    int          stored_len [64];
    int          stored_cnt;

    // free running clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    bloom_filter_insert_search_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_key_byte   (i_key_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_was_search (o_was_search)
    );

    bfis_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_operation  (i_operation),
        .i_key_byte   (i_key_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (o_valid),
        .i_found      (o_found),
        .i_was_search (o_was_search),
        .o_pending    (pending),
        .o_fail_cnt   (fail_cnt),
        .o_hit_cnt    (hit_cnt)
    );

    // one command word; called and returning at a falling edge, start left high
    task automatic send_word(input logic op, input logic [7:0] b, input logic last);
        if ($urandom_range(0, 99) < gap_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        start = 1'b1;
        i_operation = op;
        i_key_byte = b;
        i_last_byte = last;
        // the word goes in at the first rising edge with busy low
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
        words_sent++;
    endtask

    // send cur_key; operation on the earlier bytes is noise, only the last counts
    task automatic send_key(input logic op);
        for (int k = 0; k < cur_len; k++)
            send_word((k == cur_len - 1) ? op : logic'($urandom_range(0, 1)),
                      cur_key[k], k == cur_len - 1);
        if (op == OP_INSERT) begin
            stored_key[stored_cnt % 64] = cur_key;
            stored_len[stored_cnt % 64] = cur_len;
            stored_cnt++;
        end
        keys_sent++;
    endtask

    // size register writes happen only with the core drained
    task automatic write_size(input logic [SIZE_W-1:0] val);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        // a pending non-last byte is already held in the front end hash registers across the write
        repeat (300) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // random key: mostly well formed text, sometimes with zeros in it
    task automatic make_key();
        int shape;
        shape = $urandom_range(0, 9);
        cur_len = $urandom_range(1, 8);
        for (int k = 0; k < 8; k++)
            cur_key[k] = (shape == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(1, 255));
        if (shape == 1) cur_key[$urandom_range(0, cur_len - 1)] = 8'h00;
    endtask

    task automatic random_keys(input int n_words);
        int goal;
        int pick;
        goal = words_sent + n_words;
        while (words_sent < goal) begin
            // idling comes and goes in stretches
            if (!idle_off && $urandom_range(0, 15) == 0)
                gap_pct = ($urandom_range(0, 1) == 0) ? 0 : 30;
            if ($urandom_range(0, 1) == 0 && stored_cnt > 0) begin
                // search for an earlier inserted key, usually a hit
                pick = $urandom_range(0, ((stored_cnt < 64) ? stored_cnt : 64) - 1);
                cur_key = stored_key[pick];
                cur_len = stored_len[pick];
                send_key(OP_SEARCH);
            end else begin
                make_key();
                send_key(logic'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        start = 1'b0;
        i_operation = OP_INSERT;
        i_key_byte = 8'h00;
        i_last_byte = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        words_sent = 0;
        keys_sent = 0;
        stored_cnt = 0;
        gap_pct = 0;
        idle_off = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset size, single byte extremes, insert then search
        cur_len = 1; cur_key[0] = 8'hff; send_key(OP_INSERT);
        send_key(OP_SEARCH);
        cur_key[0] = 8'h01; send_key(OP_SEARCH);
        // zero as first byte hashes as the empty string
        cur_len = 3; cur_key[0] = 8'h00; cur_key[1] = 8'h5a; cur_key[2] = 8'ha5;
        send_key(OP_SEARCH);
        send_key(OP_INSERT);
        cur_len = 1; cur_key[0] = 8'h00; send_key(OP_SEARCH);
        // bytes after a zero do not change the hash
        cur_len = 4; cur_key[0] = 8'h41; cur_key[1] = 8'h00;
        cur_key[2] = 8'hff; cur_key[3] = 8'h7e;
        send_key(OP_INSERT);
        cur_len = 2; send_key(OP_SEARCH);

        // size change in the middle of a key: the size at the last byte rules
        send_word(OP_INSERT, 8'h33, 1'b0);
        send_word(OP_SEARCH, 8'hcc, 1'b0);
        write_size(SIZE_W'(0));
        send_word(OP_INSERT, 8'h80, 1'b1);
        // zero size acts as one byte, oversize acts as the full store
        cur_len = 2; cur_key[0] = 8'h12; cur_key[1] = 8'h34; send_key(OP_SEARCH);
        write_size('1);
        send_key(OP_SEARCH);
        send_key(OP_INSERT);
        send_key(OP_SEARCH);
        write_size(SIZE_W'(1));
        send_key(OP_INSERT);
        send_key(OP_SEARCH);

        // random phases over a spread of sizes, the extremes among them
        gap_pct = 30;
        write_size(SIZE_W'(MAX_BYTES)); random_keys(220);
        write_size(SIZE_W'(1));         random_keys(160);
        write_size(SIZE_W'(2));         random_keys(160);
        write_size('1);                 random_keys(220);
        write_size(SIZE_W'(0));         random_keys(120);
        write_size(SIZE_W'($urandom_range(3, 200)));  random_keys(220);
        write_size(SIZE_W'($urandom_range(201, 8191))); random_keys(220);
        // last stretch runs back to back with no idling
        write_size(SIZE_W'(MAX_BYTES));
        gap_pct = 0;
        idle_off = 1'b1;
        random_keys(200);

        // drain, then let the back end settle
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("covered %0d command words in %0d keys, %0d search hits, sizes 0 to 8191",
                 words_sent, keys_sent, hit_cnt);
        if (fail_cnt == 0)
            $display("bloom_filter_insert_search_core regression: pass");
        else
            $display("bloom_filter_insert_search_core regression: fail");
        $finish;
    end

    // watchdog well above the slowest correct run
    initial begin
        #20_000_000;
        $display("timeout after %0d words, %0d results outstanding", words_sent, pending);
        $display("bloom_filter_insert_search_core regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bfis_pkg.sv
rtl/bfis_ram.sv
rtl/bfis_front.sv
rtl/bfis_queue.sv
rtl/bfis_back.sv
rtl/bloom_filter_insert_search_core.sv
tb/bfis_checker.sv
tb/tb_top.sv
